/* design/ckl_pkg.sv */
// shared types, request and status codes for the compacting key list
package ckl_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_CHARS   = 8;
    localparam int KEY_W       = 64;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_COUNT  = 2'd2;
    // spare code, handled as a count
    localparam logic [1:0] REQ_SPARE  = 2'd3;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_REMOVED  = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_COUNTED  = 3'd4;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [KEY_W-1:0] key;
    } t_ckl_req;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] position;
        logic [4:0] entry_count;
    } t_ckl_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPARE,
        S_UPDATE
    } t_ckl_state;

    typedef struct packed {
        logic load;
        logic compare;
        logic update;
    } t_ckl_cmd;

endpackage

/* design/compacting_key_list.sv */
// a request taken at start && !busy is loaded, compared against all slots in parallel, then applied
// in the update step; busy stays high until then, so a new request waits until the last is through
// result is shown for one cycle on o_done; the receiver cannot stall it
// busy is high for the compare and update cycles and low while the result shows
// synchronous active-low reset empties every slot and clears the count
module compacting_key_list #(
    parameter int MAX_ENTRIES = ckl_pkg::MAX_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ckl_pkg::t_ckl_req i_req,
    output logic              o_done,
    output ckl_pkg::t_ckl_res o_res
);

    ckl_pkg::t_ckl_cmd cmd;

    ckl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    ckl_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_res   (o_res)
    );

endmodule

/* design/ckl_ctrl.sv */
// sequencing of one request: load, compare all slots, update
module ckl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output ckl_pkg::t_ckl_cmd o_cmd
);

    ckl_pkg::t_ckl_state r_state;
    ckl_pkg::t_ckl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ckl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_busy        = 1'b1;
        case (r_state)
            ckl_pkg::S_IDLE: begin
                o_busy    = 1'b0;
                o_cmd.load = i_start;
                if (i_start) begin
                    n_state = ckl_pkg::S_COMPARE;
                end
            end
            ckl_pkg::S_COMPARE: begin
                o_cmd.compare = 1'b1;
                n_state       = ckl_pkg::S_UPDATE;
            end
            ckl_pkg::S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ckl_pkg::S_IDLE;
            end
            default: begin
                n_state = ckl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* design/ckl_datapath.sv */
// slot registers, key compare, shift-up on remove and result register
module ckl_datapath #(
    parameter int MAX_ENTRIES = ckl_pkg::MAX_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ckl_pkg::t_ckl_cmd i_cmd,
    input  ckl_pkg::t_ckl_req i_req,
    output logic              o_done,
    output ckl_pkg::t_ckl_res o_res
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int KW    = ckl_pkg::KEY_W;
    localparam logic [MAX_ENTRIES-1:0] ALL_ONES = {MAX_ENTRIES{1'b1}};

    logic [KW-1:0]          r_slots [MAX_ENTRIES];
    logic [KW-1:0]          n_slots [MAX_ENTRIES];
    logic [CNT_W-1:0]       r_occ;
    logic [CNT_W-1:0]       n_occ;
    logic [KW-1:0]          r_key;
    logic [KW-1:0]          n_key;
    logic [1:0]             r_req;
    logic [MAX_ENTRIES-1:0] r_match;
    logic [MAX_ENTRIES-1:0] shift_en;
    logic                   r_done;
    ckl_pkg::t_ckl_res      r_res;
    ckl_pkg::t_ckl_res      n_res;
    logic [2:0]             status;
    logic [CNT_W:0]         pos;
    logic [CNT_W+5:0]       pos_x;
    logic [CNT_W+4:0]       cnt_x;
    logic                   found;

    // key ends at its first zero byte and is cut to KEY_CHARS characters
    always_comb begin
        logic       alive;
        logic [7:0] byte_v;
        alive = 1'b1;
        n_key = '0;
        for (int b = 0; b < 8; b++) begin
            byte_v = i_req.key[KW-8-8*b +: 8];
            alive  = alive && (byte_v != 8'd0) && (b < ckl_pkg::KEY_CHARS);
            if (alive) begin
                n_key[KW-8-8*b +: 8] = byte_v;
            end
        end
    end

    // a slot moves up when it or any earlier slot matches
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            shift_en[i] = |(r_match & (ALL_ONES >> (MAX_ENTRIES - 1 - i)));
        end
    end

    assign found = |r_match;

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            n_slots[i] = r_slots[i];
        end
        n_occ  = r_occ;
        status = ckl_pkg::ST_COUNTED;
        pos    = '0;
        case (r_req)
            ckl_pkg::REQ_INSERT: begin
                if (r_occ >= CNT_W'(MAX_ENTRIES)) begin
                    status = ckl_pkg::ST_FULL;
                end else begin
                    status = ckl_pkg::ST_INSERTED;
                    pos    = {1'b0, r_occ} + 1'b1;
                    if (r_key != '0) begin
                        for (int i = 0; i < MAX_ENTRIES; i++) begin
                            if (r_occ == CNT_W'(i)) begin
                                n_slots[i] = r_key;
                            end
                        end
                        n_occ = r_occ + 1'b1;
                    end
                end
            end
            ckl_pkg::REQ_REMOVE: begin
                if (found) begin
                    status = ckl_pkg::ST_REMOVED;
                    for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
                        if (shift_en[i]) begin
                            n_slots[i] = r_slots[i+1];
                        end
                    end
                    if (shift_en[MAX_ENTRIES-1]) begin
                        n_slots[MAX_ENTRIES-1] = '0;
                    end
                    if (r_key != '0 && r_occ != '0) begin
                        n_occ = r_occ - 1'b1;
                    end
                end else begin
                    status = ckl_pkg::ST_NOTFOUND;
                end
            end
            default: begin
                status = ckl_pkg::ST_COUNTED;
            end
        endcase
        pos_x             = {5'b0, pos};
        cnt_x             = {5'b0, n_occ};
        n_res.status      = status;
        n_res.position    = pos_x[4:0];
        n_res.entry_count = cnt_x[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_slots[i] <= '0;
            end
            r_occ  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.update;
            if (i_cmd.update) begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    r_slots[i] <= n_slots[i];
                end
                r_occ <= n_occ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= n_key;
            r_req <= i_req.req_type;
        end
        if (i_cmd.compare) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_match[i] <= (r_slots[i] == r_key);
            end
        end
        if (i_cmd.update) begin
            r_res <= n_res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

/* design/ckl_checker.sv */
// port-level checks for the compacting key list, bound to the top level
module ckl_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input ckl_pkg::t_ckl_res o_res
);

    // every taken request is followed by its result on o_done
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_done)
        else $error("result missing three cycles after a request");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a request was taken");

    a_free_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("busy while a result is shown");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_position_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status != ckl_pkg::ST_INSERTED) |-> (o_res.position == 5'd0))
        else $error("non-zero position on a result other than an insert");

endmodule

bind compacting_key_list ckl_checker u_ckl_checker (.*);
